// File: design/assert_macros.svh
// assert_macros.svh: assertion macros shared by the light level bucketizer RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define LLB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("llb assertion failed");

// Clocked check that also holds during reset.
`define LLB_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("llb assertion failed");

`endif

// File: design/llb_pkg.sv
// llb_pkg: types, constants and register codes of the light level bucketizer.
// No dependencies; imported by every module of the block.
package llb_pkg;

   // Default parameter values
   localparam int READING_BITS_DEF   = 24;
   localparam int GAIN_FRAC_BITS_DEF = 16;

   // Fraction bits of the threshold registers
   localparam int REG_FRAC = 16;

   // Configuration port
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      CSR_CALIBRATION = 2'd0,
      CSR_LIGHT_GAIN  = 2'd1,
      CSR_DROP_DARK   = 2'd2,
      CSR_RISE_DARK   = 2'd3
   } csr_index_type;

   // Register reset values
   localparam logic [31:0] CAL_RESET  = 32'd0;
   localparam logic [31:0] GAIN_RESET = 32'd65536;
   localparam logic [31:0] DROP_RESET = 32'd65536;
   localparam logic [31:0] RISE_RESET = 32'd131072;

   // Calibration words below this select the piecewise map
   localparam logic signed [31:0] CAL_LIMIT = 32'sd60001;

   // Piecewise map breakpoints
   localparam int PW_LIMIT_5    = 50;
   localparam int PW_LIMIT_10   = 200;
   localparam int PW_LIMIT_50   = 1000;
   localparam int PW_LIMIT_1000 = 2000;

   // Reciprocal multipliers: x*205>>10 = x/5, x*205>>11 = x/10, x*41>>11 = x/50
   localparam logic [15:0] RECIP_5_10 = 16'd205;
   localparam logic [15:0] RECIP_50   = 16'd41;

   // Levels of the ladder
   localparam logic [5:0] LVL_0  = 6'd0;
   localparam logic [5:0] LVL_3  = 6'd3;
   localparam logic [5:0] LVL_6  = 6'd6;
   localparam logic [5:0] LVL_10 = 6'd10;
   localparam logic [5:0] LVL_12 = 6'd12;
   localparam logic [5:0] LVL_19 = 6'd19;
   localparam logic [5:0] LVL_25 = 6'd25;
   localparam logic [5:0] LVL_26 = 6'd26;
   localparam logic [5:0] LVL_41 = 6'd41;
   localparam logic [5:0] LVL_42 = 6'd42;

   // Integer hysteresis thresholds on scaled light
   localparam int TH_UP_6    = 6;
   localparam int TH_UP_12   = 12;
   localparam int TH_UP_19   = 120;
   localparam int TH_UP_26   = 496;
   localparam int TH_UP_42   = 1440;
   localparam int TH_DN_3    = 4;
   localparam int TH_DN_6    = 8;
   localparam int TH_DN_12   = 75;
   localparam int TH_DN_19   = 372;
   localparam int TH_DN_26   = 960;

   // Configuration registers as seen by the datapath
   typedef struct packed {
      logic [31:0] calibration_word;
      logic [31:0] light_gain;
      logic [31:0] drop_to_dark_threshold;
      logic [31:0] rise_from_dark_threshold;
   } cfg_type;

   // Control word carried from the front stage to the hysteresis stage
   typedef struct packed {
      logic       ok;
      logic       hyst;
      logic [5:0] pw_level;
   } stage_ctl_type;

endpackage

// File: design/llb_csr.sv
// llb_csr: APB-style configuration registers of the light level bucketizer.
// Depends on llb_pkg.
module llb_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [llb_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [llb_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [llb_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready,
   output llb_pkg::cfg_type                   cfg
);
   import llb_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   csr_index_type idx;
   logic          wr_en;

   assign idx    = csr_index_type'(paddr[3:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_CALIBRATION: cfg_in.calibration_word         = pwdata;
            CSR_LIGHT_GAIN:  cfg_in.light_gain               = pwdata;
            CSR_DROP_DARK:   cfg_in.drop_to_dark_threshold   = pwdata;
            CSR_RISE_DARK:   cfg_in.rise_from_dark_threshold = pwdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.calibration_word         <= CAL_RESET;
         cfg_ff.light_gain               <= GAIN_RESET;
         cfg_ff.drop_to_dark_threshold   <= DROP_RESET;
         cfg_ff.rise_from_dark_threshold <= RISE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (idx)
         CSR_CALIBRATION: prdata = cfg_ff.calibration_word;
         CSR_LIGHT_GAIN:  prdata = cfg_ff.light_gain;
         CSR_DROP_DARK:   prdata = cfg_ff.drop_to_dark_threshold;
         CSR_RISE_DARK:   prdata = cfg_ff.rise_from_dark_threshold;
         default:         prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule

// File: design/llb_front.sv
// llb_front: input register stage; validity check, piecewise map and gain multiply.
// Depends on llb_pkg.
module llb_front #(
   parameter int READING_BITS = llb_pkg::READING_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          sensor_ready,
   input  logic                          read_failed,
   input  logic [READING_BITS-1:0]       reading,
   input  llb_pkg::cfg_type              cfg,
   output logic                          out_valid,
   input  logic                          out_ready,
   output llb_pkg::stage_ctl_type        out_ctl,
   output logic [READING_BITS+31:0]      out_product
);
   import llb_pkg::*;

   localparam int PW = READING_BITS + 32;

   // Input register
   logic                    valid_ff, valid_in;
   logic                    ready_ff, failed_ff;
   logic [READING_BITS-1:0] reading_ff;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         ready_ff   <= sensor_ready;
         failed_ff  <= read_failed;
         reading_ff <= reading;
      end
   end

   // Piecewise map: steps of 5, 10 and 50 via reciprocal multiplies, then 41, then 42
   logic [7:0]  x10;
   logic [9:0]  x50;
   logic [15:0] p5, p10, p50;
   logic [5:0]  pw_level;

   assign x10 = reading_ff[7:0] - 8'(PW_LIMIT_5);
   assign x50 = reading_ff[9:0] - 10'(PW_LIMIT_10);
   assign p5  = 16'(reading_ff[5:0]) * RECIP_5_10;
   assign p10 = 16'(x10) * RECIP_5_10;
   assign p50 = 16'(x50) * RECIP_50;

   always_comb begin
      priority if (reading_ff < READING_BITS'(PW_LIMIT_5)) begin
         pw_level = 6'(p5[13:10]);
      end else if (reading_ff < READING_BITS'(PW_LIMIT_10)) begin
         pw_level = 6'(p10[14:11]) + LVL_10;
      end else if (reading_ff < READING_BITS'(PW_LIMIT_50)) begin
         pw_level = 6'(p50[15:11]) + LVL_25;
      end else if (reading_ff < READING_BITS'(PW_LIMIT_1000)) begin
         pw_level = LVL_41;
      end else begin
         pw_level = LVL_42;
      end
   end

   // Stage outputs
   assign out_valid        = valid_ff;
   assign out_ctl.ok       = ready_ff && !failed_ff && (reading_ff != '0);
   assign out_ctl.hyst     = !($signed(cfg.calibration_word) < CAL_LIMIT);
   assign out_ctl.pw_level = pw_level;
   assign out_product      = PW'(reading_ff) * PW'(cfg.light_gain);
endmodule

// File: design/llb_hyst.sv
// llb_hyst: threshold compares, hysteresis level state and the result register.
// Depends on llb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module llb_hyst #(
   parameter int READING_BITS   = llb_pkg::READING_BITS_DEF,
   parameter int GAIN_FRAC_BITS = llb_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  llb_pkg::stage_ctl_type    in_ctl,
   input  logic [READING_BITS+31:0]  in_product,
   input  llb_pkg::cfg_type          cfg,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      level_valid,
   output logic [5:0]                level
);
   import llb_pkg::*;

   localparam int PW   = READING_BITS + 32;
   localparam int CW   = PW + 16;
   localparam int SH_S = (GAIN_FRAC_BITS < REG_FRAC) ? REG_FRAC - GAIN_FRAC_BITS : 0;
   localparam int SH_T = (GAIN_FRAC_BITS > REG_FRAC) ? GAIN_FRAC_BITS - REG_FRAC : 0;

   // Product and thresholds aligned to a common binary point
   logic [CW-1:0] s_reg, s_int, rise_t, drop_t;
   assign s_reg  = CW'(in_product) << SH_S;
   assign s_int  = CW'(in_product);
   assign rise_t = CW'(cfg.rise_from_dark_threshold) << SH_T;
   assign drop_t = CW'(cfg.drop_to_dark_threshold) << SH_T;

   function automatic logic [CW-1:0] ith(input int c);
      ith = CW'(c) << GAIN_FRAC_BITS;
   endfunction

   // All strict compares in parallel
   logic gt_rise, lt_drop, gt6, gt12, gt120, gt496, gt1440;
   logic lt4, lt8, lt75, lt372, lt960;
   assign gt_rise = s_reg > rise_t;
   assign lt_drop = s_reg < drop_t;
   assign gt6     = s_int > ith(TH_UP_6);
   assign gt12    = s_int > ith(TH_UP_12);
   assign gt120   = s_int > ith(TH_UP_19);
   assign gt496   = s_int > ith(TH_UP_26);
   assign gt1440  = s_int > ith(TH_UP_42);
   assign lt4     = s_int < ith(TH_DN_3);
   assign lt8     = s_int < ith(TH_DN_6);
   assign lt75    = s_int < ith(TH_DN_12);
   assign lt372   = s_int < ith(TH_DN_19);
   assign lt960   = s_int < ith(TH_DN_26);

   // Hysteresis step from the stored level
   logic [5:0] state_ff, state_in, next_lv;
   always_comb begin
      next_lv = state_ff;
      unique case (state_ff)
         LVL_0:  if (gt_rise) next_lv = LVL_3;
         LVL_3:  begin
            if (gt6)          next_lv = LVL_6;
            else if (lt_drop) next_lv = LVL_0;
         end
         LVL_6:  begin
            if (gt12)         next_lv = LVL_12;
            else if (lt4)     next_lv = LVL_3;
         end
         LVL_12: begin
            if (gt120)        next_lv = LVL_19;
            else if (lt8)     next_lv = LVL_6;
         end
         LVL_19: begin
            if (gt496)        next_lv = LVL_26;
            else if (lt75)    next_lv = LVL_12;
         end
         LVL_26: begin
            if (gt1440)       next_lv = LVL_42;
            else if (lt372)   next_lv = LVL_19;
         end
         LVL_42: if (lt960)   next_lv = LVL_26;
         default:             next_lv = state_ff;
      endcase
   end

   // Handshake and state update
   logic adv, upd;
   assign in_ready = !rsp_valid || rsp_ready;
   assign adv      = in_valid && in_ready;
   assign upd      = adv && in_ctl.ok && in_ctl.hyst;
   assign state_in = upd ? next_lv : state_ff;

   logic       valid_ff, ok_ff;
   logic [5:0] level_ff, level_in;

   always_comb begin
      priority if (!in_ctl.ok) begin
         level_in = LVL_0;
      end else if (in_ctl.hyst) begin
         level_in = next_lv;
      end else begin
         level_in = in_ctl.pw_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         state_ff <= LVL_0;
      end else begin
         state_ff <= state_in;
         if (in_ready) begin
            valid_ff <= in_valid;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (adv) begin
         ok_ff    <= in_ctl.ok;
         level_ff <= level_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign level_valid = ok_ff;
   assign level       = level_ff;

   // Checks
   `LLB_ASSERT(a_level_range, clock, reset, rsp_valid |-> (level <= LVL_42))
   `LLB_ASSERT(a_invalid_zero, clock, reset, (rsp_valid && !level_valid) |-> (level == LVL_0))
   `LLB_ASSERT(a_state_hold, clock, reset, (!reset && !upd) |=> (state_ff == $past(state_ff)))
   `LLB_ASSERT(a_state_ladder, clock, reset,
      (state_ff == LVL_0) || (state_ff == LVL_3) || (state_ff == LVL_6) ||
      (state_ff == LVL_12) || (state_ff == LVL_19) || (state_ff == LVL_26) ||
      (state_ff == LVL_42))
endmodule

// File: design/light_level_bucketizer_unit.sv
// light_level_bucketizer_unit: top level of the light level bucketizer.
// Depends on llb_pkg, llb_csr, llb_front and llb_hyst.
//
//   channel | ports                           | moves
//   req     | req_valid / req_ready           | one reading word per accept
//   rsp     | rsp_valid / rsp_ready           | one level word per reading
//   csr     | psel penable pwrite paddr ...   | one 32-bit register word per write
//
// From req accept to rsp_valid a word passes an input register feeding the gain
// multiplier, then the compare bank and hysteresis state into the result register.
// One word per cycle is sustained while rsp is not stalled; the stored level is updated
// as a word enters the result register, so the next word sees it. Reset is synchronous,
// active high, clears the pipeline valids and stored level and restores register defaults.
// A stalled rsp holds its word while one more req word can still fill the input stage.
module light_level_bucketizer_unit #(
   parameter int READING_BITS   = llb_pkg::READING_BITS_DEF,
   parameter int GAIN_FRAC_BITS = llb_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_sensor_ready,
   input  logic                               req_read_failed,
   input  logic [READING_BITS-1:0]            req_reading,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_level_valid,
   output logic [5:0]                         rsp_level,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [llb_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [llb_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [llb_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);
   import llb_pkg::*;

   cfg_type                 cfg;
   stage_ctl_type           mid_ctl;
   logic                    mid_valid, mid_ready;
   logic [READING_BITS+31:0] mid_product;

   // Configuration registers
   llb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Input stage
   llb_front #(
      .READING_BITS (READING_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .sensor_ready (req_sensor_ready),
      .read_failed  (req_read_failed),
      .reading      (req_reading),
      .cfg          (cfg),
      .out_valid    (mid_valid),
      .out_ready    (mid_ready),
      .out_ctl      (mid_ctl),
      .out_product  (mid_product)
   );

   // Hysteresis and result stage
   llb_hyst #(
      .READING_BITS   (READING_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_hyst (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (mid_valid),
      .in_ready    (mid_ready),
      .in_ctl      (mid_ctl),
      .in_product  (mid_product),
      .cfg         (cfg),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .level_valid (rsp_level_valid),
      .level       (rsp_level)
   );
endmodule

// File: bench/tb_light_level_bucketizer_unit.sv
// tb_light_level_bucketizer_unit: self-checking bench for the light level bucketizer.
// Depends on llb_pkg and light_level_bucketizer_unit; drives readings, register writes
// and result back-pressure, and checks every level word against an in-bench predictor.
module tb_light_level_bucketizer_unit;
   import llb_pkg::*;

   localparam int RB         = READING_BITS_DEF;
   localparam int GAIN_FRAC  = GAIN_FRAC_BITS_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_WORDS = 170;
   localparam int HOLD_CYCLES = 300;
   localparam int LADDER_MARKS [12] = '{1, 2, 4, 6, 8, 12, 75, 120, 372, 496, 960, 1440};

   typedef struct {
      logic       level_valid;
      logic [5:0] level;
   } level_word_type;

   // Predictor of the bucketizer plus the queue of levels still owed by the block
   class level_scoreboard;
      logic [31:0] cal_word;
      logic [31:0] gain;
      logic [31:0] drop_th;
      logic [31:0] rise_th;
      logic [5:0]  stored_level;
      level_word_type pending[$];
      int          errors;

      function new();
         cal_word     = CAL_RESET;
         gain         = GAIN_RESET;
         drop_th      = DROP_RESET;
         rise_th      = RISE_RESET;
         stored_level = LVL_0;
         errors       = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_CALIBRATION: cal_word = value;
            CSR_LIGHT_GAIN:  gain     = value;
            CSR_DROP_DARK:   drop_th  = value;
            CSR_RISE_DARK:   rise_th  = value;
         endcase
      endfunction

      // Fixed map used when the calibration word is low
      function logic [5:0] piecewise_level(logic [RB-1:0] rd);
         int unsigned r;
         r = rd;
         if (r < PW_LIMIT_5) return 6'(r / 5);
         if (r < PW_LIMIT_10) return 6'((r - PW_LIMIT_5) / 10 + LVL_10);
         if (r < PW_LIMIT_50) return 6'((r - PW_LIMIT_10) / 50 + LVL_25);
         if (r < PW_LIMIT_1000) return LVL_41;
         return LVL_42;
      endfunction

      // Integer threshold moved to the scaled-light fraction
      function logic [63:0] units(int n);
         return 64'(n) << GAIN_FRAC;
      endfunction

      function logic [63:0] reg_units(logic [31:0] t);
         return 64'(t) << (GAIN_FRAC - REG_FRAC);
      endfunction

      // One step of the hysteresis ladder; all tests are strict
      function logic [5:0] next_level(logic [5:0] lv, logic [63:0] s);
         case (lv)
            LVL_0: begin
               if (s > reg_units(rise_th)) return LVL_3;
            end
            LVL_3: begin
               if (s > units(TH_UP_6)) return LVL_6;
               else if (s < reg_units(drop_th)) return LVL_0;
            end
            LVL_6: begin
               if (s > units(TH_UP_12)) return LVL_12;
               else if (s < units(TH_DN_3)) return LVL_3;
            end
            LVL_12: begin
               if (s > units(TH_UP_19)) return LVL_19;
               else if (s < units(TH_DN_6)) return LVL_6;
            end
            LVL_19: begin
               if (s > units(TH_UP_26)) return LVL_26;
               else if (s < units(TH_DN_12)) return LVL_12;
            end
            LVL_26: begin
               if (s > units(TH_UP_42)) return LVL_42;
               else if (s < units(TH_DN_19)) return LVL_19;
            end
            LVL_42: begin
               if (s < units(TH_DN_26)) return LVL_26;
            end
            default: ;
         endcase
         return lv;
      endfunction

      function void note_reading(logic rdy, logic fail, logic [RB-1:0] rd);
         level_word_type w;
         logic [63:0] s;
         w.level_valid = 1'b0;
         w.level       = LVL_0;
         if (rdy && !fail && rd != '0) begin
            w.level_valid = 1'b1;
            if ($signed(cal_word) < CAL_LIMIT) begin
               w.level = piecewise_level(rd);
            end else begin
               s = 64'(rd) * 64'(gain);
               stored_level = next_level(stored_level, s);
               w.level = stored_level;
            end
         end
         pending.push_back(w);
      endfunction

      function void check_level(logic lv_valid, logic [5:0] lv);
         level_word_type w;
         if (pending.size() == 0) begin
            $error("level word with nothing expected: level_valid %0d level %0d",
                   lv_valid, lv);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (lv_valid !== w.level_valid) begin
            $error("level_valid mismatch: expected %0d, actual %0d", w.level_valid, lv_valid);
            errors++;
         end
         if (lv !== w.level) begin
            $error("level mismatch: expected %0d, actual %0d", w.level, lv);
            errors++;
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_sensor_ready;
   logic                     req_read_failed;
   logic [RB-1:0]            req_reading;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic                     rsp_level_valid;
   logic [5:0]               rsp_level;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   level_scoreboard sb;
   int  src_idle_pct;
   int  dst_idle_pct;
   bit  hold_armed;
   bit  hold_done;
   int  hold_count;
   int  cycle_count;

   light_level_bucketizer_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sensor_ready (req_sensor_ready),
      .req_read_failed  (req_read_failed),
      .req_reading      (req_reading),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_level_valid  (rsp_level_valid),
      .rsp_level        (rsp_level),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off when armed
   initial begin
      rsp_ready  = 1'b0;
      hold_done  = 1'b0;
      hold_count = 0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_done) begin
            rsp_ready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= dst_idle_pct);
         end
      end
   end

   // Monitor: note accepted readings, check accepted level words
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_level(rsp_level_valid, rsp_level);
         if (req_valid && req_ready)
            sb.note_reading(req_sensor_ready, req_read_failed, req_reading);
      end
   end

   // Offer one reading word, idling first at random, and wait for its accept
   task automatic send_reading(logic rdy, logic fail, logic [RB-1:0] rd);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sensor_ready <= rdy;
      req_read_failed  <= fail;
      req_reading      <= rd;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Register write followed by a read-back
   task automatic csr_write(csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_BITS'({idx, 2'b00});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(idx, value);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== value) begin
         $error("register %s read-back: expected 0x%08h, actual 0x%08h",
                idx.name(), value, prdata);
         sb.errors++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Let every owed level word come out, then a few cycles of margin
   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Reading aimed at the ladder thresholds for the current gain
   function automatic logic [RB-1:0] pick_reading();
      int          roll;
      int          target;
      logic [63:0] r;
      roll = $urandom_range(99);
      if (roll < 10) return RB'($urandom);
      if (roll < 20 || sb.gain == '0) return RB'($urandom_range(2100));
      if (roll < 30) target = $urandom_range(2000);
      else if (roll < 40) target = int'(sb.drop_th >> REG_FRAC) + $urandom_range(2);
      else if (roll < 50) target = int'(sb.rise_th >> REG_FRAC) + $urandom_range(2);
      else target = LADDER_MARKS[$urandom_range(11)] + $urandom_range(4) - 2;
      if (target < 0) target = 0;
      r = ((64'(target) << GAIN_FRAC) / 64'(sb.gain)) + 64'($urandom_range(2)) - 64'd1;
      if (r > 64'({RB{1'b1}})) r = 64'({RB{1'b1}});
      return r[RB-1:0];
   endfunction

   // Register settings of one random phase
   task automatic setup_phase(int p);
      logic [31:0] cal, gain, drop, rise;
      case (p)
         0: begin
            cal = 32'h7fff_ffff; gain = GAIN_RESET; drop = '0; rise = '0;
         end
         1: begin
            cal = 32'h8000_0000; gain = $urandom; drop = $urandom; rise = $urandom;
         end
         2: begin
            cal = 32'd60000; gain = GAIN_RESET; drop = DROP_RESET; rise = RISE_RESET;
         end
         3: begin
            cal = 32'd60001; gain = '1; drop = '1; rise = '1;
         end
         4: begin
            cal  = $urandom_range(32'h7fff_ffff, 60001);
            gain = $urandom_range(1 << 20, 1 << 12);
            drop = $urandom_range(8 << 16);
            rise = $urandom_range(16 << 16);
         end
         5: begin
            cal = $urandom; gain = '0; drop = $urandom_range(4 << 16); rise = $urandom_range(4 << 16);
         end
         6: begin
            cal  = 32'd60001;
            gain = $urandom_range(4 << 16, 1 << 15);
            drop = $urandom_range(8 << 16);
            rise = $urandom_range(16 << 16);
         end
         7: begin
            cal = 32'h7fff_ffff; gain = $urandom; drop = $urandom; rise = $urandom;
         end
         default: begin
            cal  = $urandom_range(32'h7fff_ffff, 60001);
            gain = $urandom_range(1 << 18, 1 << 14);
            drop = $urandom_range(8 << 16);
            rise = $urandom_range(16 << 16);
         end
      endcase
      csr_write(CSR_CALIBRATION, cal);
      csr_write(CSR_LIGHT_GAIN, gain);
      csr_write(CSR_DROP_DARK, drop);
      csr_write(CSR_RISE_DARK, rise);
   endtask

   // Main sequence
   initial begin
      sb               = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sensor_ready = 1'b0;
      req_read_failed  = 1'b0;
      req_reading      = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      hold_armed       = 1'b0;
      src_idle_pct     = 15;
      dst_idle_pct     = 56;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Invalid words and piecewise breakpoints at reset settings
      send_reading(1'b0, 1'b0, 24'd500);
      send_reading(1'b1, 1'b1, 24'd500);
      send_reading(1'b1, 1'b0, 24'd0);
      send_reading(1'b1, 1'b0, 24'd1);
      send_reading(1'b1, 1'b0, 24'd49);
      send_reading(1'b1, 1'b0, 24'd50);
      send_reading(1'b1, 1'b0, 24'd199);
      send_reading(1'b1, 1'b0, 24'd200);
      send_reading(1'b1, 1'b0, 24'd999);
      send_reading(1'b1, 1'b0, 24'd1000);
      send_reading(1'b1, 1'b0, 24'd2000);
      send_reading(1'b1, 1'b0, {RB{1'b1}});
      stop_sending();
      drain();

      // Walk the ladder up and down at unity gain, with ties on thresholds
      csr_write(CSR_CALIBRATION, 32'd60001);
      send_reading(1'b1, 1'b0, 24'd2);
      send_reading(1'b1, 1'b0, 24'd3);
      send_reading(1'b1, 1'b0, 24'd7);
      send_reading(1'b1, 1'b0, 24'd13);
      send_reading(1'b1, 1'b0, 24'd121);
      send_reading(1'b1, 1'b0, 24'd497);
      send_reading(1'b1, 1'b0, 24'd1441);
      send_reading(1'b1, 1'b0, 24'd960);
      send_reading(1'b1, 1'b0, 24'd959);
      send_reading(1'b1, 1'b0, 24'd371);
      send_reading(1'b1, 1'b0, 24'd74);
      send_reading(1'b1, 1'b0, 24'd7);
      send_reading(1'b1, 1'b0, 24'd3);
      send_reading(1'b1, 1'b0, 24'd1);
      send_reading(1'b0, 1'b1, 24'd0);
      stop_sending();
      drain();

      // Random phases, each with its own register settings
      for (int p = 0; p < 9; p++) begin
         if (p == 3) begin
            src_idle_pct = 56;
            dst_idle_pct = 15;
         end else if (p == 6) begin
            src_idle_pct = 0;
            dst_idle_pct = 0;
         end
         setup_phase(p);
         if (p == 6) hold_armed = 1'b1;
         for (int i = 0; i < PHASE_WORDS; i++) begin
            send_reading($urandom_range(99) >= 5, $urandom_range(99) < 5, pick_reading());
         end
         stop_sending();
         drain();
      end

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
